### rtl/assert_macros.svh
// assertion macros included by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

// checked only while out of reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`endif

### rtl/osset_pkg.sv
// shared types and constants of the order-statistic sorted set
`timescale 1ns / 1ps

package osset_pkg;

  localparam int unsigned CAPACITY_DEF = 64;
  localparam int unsigned KEY_BITS_DEF = 32;

  localparam int unsigned CMD_W    = 3;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned RANK_W   = 6;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 3'd0,
    CMD_ERASE  = 3'd1,
    CMD_FIND   = 3'd2,
    CMD_SELECT = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE      = 2'd0,
    STATUS_NO_EFFECT = 2'd1,
    STATUS_FULL      = 2'd2
  } status_e;

  // result of the shared key comparator
  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_t;

endpackage

### rtl/osset_cmp.sv
// shared key comparator: stored key against command key
`timescale 1ns / 1ps

module osset_cmp #(
  parameter int unsigned KEY_BITS = osset_pkg::KEY_BITS_DEF
) (
  input  logic [KEY_BITS-1:0] stored_i,
  input  logic [KEY_BITS-1:0] key_i,
  output osset_pkg::cmp_t     cmp_o
);
  import osset_pkg::*;

  assign cmp_o.lt = (stored_i < key_i);
  assign cmp_o.eq = (stored_i == key_i);

endmodule

### rtl/order_statistic_sorted_set_top.sv
// top level of the order-statistic sorted set
`timescale 1ns / 1ps

// Sorted set of up to CAPACITY distinct unsigned keys (low KEY_BITS bits of key_i) held in
// ascending order in a single-port-read, single-port-write memory, plus a count of keys held.
// One command beat in gives exactly one result beat out: insert, erase, find rank of key,
// select key at rank, or clear. Status 0 is done, 1 is no effect (duplicate insert, absent
// key, rank beyond count, unknown command) and 2 is store full. found_key is only nonzero for
// a successful select, found_rank only for a successful find, key_count is the count after
// the command. The block takes one command at a time: in_ready_o is high only while the
// sequencer is idle. Clear and unknown commands go straight to the hand-off state; a select
// with a rank below the count first reads its entry. Insert, erase and find first scan the
// memory upward from entry 0, one entry per cycle through one shared comparator, until the
// first key not below the command key (position p); insert then moves the entries at p and
// above up by one and erase moves the entries above p down by one, again one entry per cycle
// through the memory port. The result sits in an output register, so the next command can
// be accepted while the previous result still waits for out_ready_i. No clearing pass is
// needed after reset: only entries below the count are ever read.
module order_statistic_sorted_set_top #(
  parameter int unsigned CAPACITY = osset_pkg::CAPACITY_DEF,
  parameter int unsigned KEY_BITS = osset_pkg::KEY_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [osset_pkg::CMD_W-1:0]   command_i,
  input  logic [osset_pkg::KEY_W-1:0]   key_i,
  input  logic [osset_pkg::RANK_W-1:0]  rank_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [osset_pkg::STATUS_W-1:0] status_o,
  output logic [osset_pkg::KEY_W-1:0]   found_key_o,
  output logic [osset_pkg::RANK_W-1:0]  found_rank_o,
  output logic [osset_pkg::COUNT_W-1:0] key_count_o
);
  import osset_pkg::*;

  `include "assert_macros.svh"

  localparam int unsigned IDX = $clog2(CAPACITY);
  localparam int unsigned CW  = $clog2(CAPACITY + 1);
  localparam int unsigned CWX = CW + 1;

  typedef enum logic [2:0] {
    ST_IDLE,    // waiting for a command beat
    ST_SCAN,    // linear search for the lower bound
    ST_DECIDE,  // act on position and hit
    ST_ERA,     // erase: move entries down by one
    ST_INS,     // insert: move entries up by one
    ST_PUT,     // insert: write the new key
    ST_SEL,     // select: read data returns
    ST_DONE     // hand result to the output register
  } state_e;

  state_e                 state_q, state_d;
  logic [CMD_W-1:0]       cmd_q, cmd_d;
  logic [KEY_BITS-1:0]    key_q, key_d;
  logic [CW-1:0]          p_q, p_d;        // lower-bound position
  logic                   hit_q, hit_d;
  logic [CW-1:0]          i_q, i_d;        // shift write pointer
  logic [CW-1:0]          count_q, count_d;

  logic [STATUS_W-1:0]    res_status_q, res_status_d;
  logic [KEY_W-1:0]       res_key_q, res_key_d;
  logic [RANK_W-1:0]      res_rank_q, res_rank_d;

  logic                   out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]    out_status_q, out_status_d;
  logic [KEY_W-1:0]       out_key_q, out_key_d;
  logic [RANK_W-1:0]      out_rank_q, out_rank_d;
  logic [COUNT_W-1:0]     out_count_q, out_count_d;

  // key memory, one read and one write port, registered read data
  logic [KEY_BITS-1:0]    mem_q [CAPACITY];
  logic [KEY_BITS-1:0]    rd_data_q;
  logic                   rd_en;
  logic [IDX-1:0]         rd_addr;
  logic                   wr_en;
  logic [IDX-1:0]         wr_addr;
  logic [KEY_BITS-1:0]    wr_data;

  logic [63:0]            key_ext;
  logic [KEY_BITS-1:0]    key_in;
  logic [63:0]            rd_ext;
  logic                   in_fire;
  logic                   slot_free;
  cmp_t                   cmp;

  // only the low KEY_BITS of the key port take part
  assign key_ext = 64'(key_i);
  assign key_in  = key_ext[KEY_BITS-1:0];
  assign rd_ext  = 64'(rd_data_q);

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  // output register is free now or frees at this edge
  assign slot_free  = !out_valid_q || out_ready_i;

  osset_cmp #(
    .KEY_BITS (KEY_BITS)
  ) u_cmp (
    .stored_i (rd_data_q),
    .key_i    (key_q),
    .cmp_o    (cmp)
  );

  // sequencer next state and memory control
  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    key_d        = key_q;
    p_d          = p_q;
    hit_d        = hit_q;
    i_d          = i_q;
    count_d      = count_q;
    res_status_d = res_status_q;
    res_key_d    = res_key_q;
    res_rank_d   = res_rank_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_status_d = out_status_q;
    out_key_d    = out_key_q;
    out_rank_d   = out_rank_q;
    out_count_d  = out_count_q;
    rd_en        = 1'b0;
    rd_addr      = '0;
    wr_en        = 1'b0;
    wr_addr      = '0;
    wr_data      = key_q;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          cmd_d        = command_i;
          key_d        = key_in;
          p_d          = '0;
          hit_d        = 1'b0;
          res_status_d = STATUS_NO_EFFECT;
          res_key_d    = '0;
          res_rank_d   = '0;
          case (command_i)
            CMD_INSERT, CMD_ERASE, CMD_FIND: begin
              if (count_q == '0) begin
                state_d = ST_DECIDE;
              end else begin
                rd_en   = 1'b1;
                rd_addr = '0;
                state_d = ST_SCAN;
              end
            end
            CMD_SELECT: begin
              if (32'(rank_i) < 32'(count_q)) begin
                rd_en   = 1'b1;
                rd_addr = IDX'(rank_i);
                state_d = ST_SEL;
              end else begin
                state_d = ST_DONE;
              end
            end
            CMD_CLEAR: begin
              count_d      = '0;
              res_status_d = STATUS_DONE;
              state_d      = ST_DONE;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (cmp.lt) begin
          if (CWX'(p_q) + CWX'(1) < CWX'(count_q)) begin
            p_d     = p_q + CW'(1);
            rd_en   = 1'b1;
            rd_addr = IDX'(p_q + CW'(1));
          end else begin
            p_d     = count_q;
            hit_d   = 1'b0;
            state_d = ST_DECIDE;
          end
        end else begin
          hit_d   = cmp.eq;
          state_d = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        state_d = ST_DONE;
        case (cmd_q)
          CMD_FIND: begin
            if (hit_q) begin
              res_status_d = STATUS_DONE;
              res_rank_d   = RANK_W'(p_q);
            end
          end
          CMD_ERASE: begin
            if (hit_q) begin
              if (CWX'(p_q) + CWX'(1) == CWX'(count_q)) begin
                // last entry goes, nothing to move
                count_d      = count_q - CW'(1);
                res_status_d = STATUS_DONE;
              end else begin
                rd_en   = 1'b1;
                rd_addr = IDX'(p_q + CW'(1));
                i_d     = p_q;
                state_d = ST_ERA;
              end
            end
          end
          CMD_INSERT: begin
            if (hit_q) begin
              res_status_d = STATUS_NO_EFFECT;
            end else if (CWX'(count_q) >= CWX'(CAPACITY)) begin
              res_status_d = STATUS_FULL;
            end else if (p_q == count_q) begin
              // new largest key, append
              wr_en        = 1'b1;
              wr_addr      = IDX'(p_q);
              wr_data      = key_q;
              count_d      = count_q + CW'(1);
              res_status_d = STATUS_DONE;
            end else begin
              rd_en   = 1'b1;
              rd_addr = IDX'(count_q - CW'(1));
              i_d     = count_q;
              state_d = ST_INS;
            end
          end
          default: begin
          end
        endcase
      end

      ST_ERA: begin
        wr_en   = 1'b1;
        wr_addr = IDX'(i_q);
        wr_data = rd_data_q;
        if (CWX'(i_q) + CWX'(2) < CWX'(count_q)) begin
          rd_en   = 1'b1;
          rd_addr = IDX'(i_q + CW'(2));
          i_d     = i_q + CW'(1);
        end else begin
          count_d      = count_q - CW'(1);
          res_status_d = STATUS_DONE;
          state_d      = ST_DONE;
        end
      end

      ST_INS: begin
        wr_en   = 1'b1;
        wr_addr = IDX'(i_q);
        wr_data = rd_data_q;
        if (i_q - CW'(1) == p_q) begin
          state_d = ST_PUT;
        end else begin
          rd_en   = 1'b1;
          rd_addr = IDX'(i_q - CW'(2));
          i_d     = i_q - CW'(1);
        end
      end

      ST_PUT: begin
        wr_en        = 1'b1;
        wr_addr      = IDX'(p_q);
        wr_data      = key_q;
        count_d      = count_q + CW'(1);
        res_status_d = STATUS_DONE;
        state_d      = ST_DONE;
      end

      ST_SEL: begin
        res_key_d    = rd_ext[KEY_W-1:0];
        res_status_d = STATUS_DONE;
        state_d      = ST_DONE;
      end

      ST_DONE: begin
        if (slot_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_key_d    = res_key_q;
          out_rank_d   = res_rank_q;
          out_count_d  = COUNT_W'(count_q);
          state_d      = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // sequencer state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cmd_q        <= '0;
      key_q        <= '0;
      p_q          <= '0;
      hit_q        <= 1'b0;
      i_q          <= '0;
      count_q      <= '0;
      res_status_q <= '0;
      res_key_q    <= '0;
      res_rank_q   <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= '0;
      out_key_q    <= '0;
      out_rank_q   <= '0;
      out_count_q  <= '0;
    end else begin
      state_q      <= state_d;
      cmd_q        <= cmd_d;
      key_q        <= key_d;
      p_q          <= p_d;
      hit_q        <= hit_d;
      i_q          <= i_d;
      count_q      <= count_d;
      res_status_q <= res_status_d;
      res_key_q    <= res_key_d;
      res_rank_q   <= res_rank_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_key_q    <= out_key_d;
      out_rank_q   <= out_rank_d;
      out_count_q  <= out_count_d;
    end
  end

  // key memory
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign found_key_o  = out_key_q;
  assign found_rank_o = out_rank_q;
  assign key_count_o  = out_count_q;

  // count never passes the store size
  `ASSERT_CLK(a_count_bound, CWX'(count_q) <= CWX'(CAPACITY), "key count above capacity")
  // count moves by one per command or drops to zero on clear
  `ASSERT_CLK(a_count_step, (count_q != $past(count_q)) |-> (count_q == $past(count_q) + CW'(1) || count_q == $past(count_q) - CW'(1) || count_q == '0), "key count jumped")
  // one command at a time
  `ASSERT_CLK(a_busy_after_accept, (in_valid_i && in_ready_o) |=> !in_ready_o, "ready right after a command beat")
  // a result beat only appears from the hand-off state
  `ASSERT_CLK(a_out_from_done, $rose(out_valid_q) |-> $past(state_q == ST_DONE), "result beat without a finished command")

endmodule
